@@ hw/rtl/bpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bpr_pkg;

    localparam int COORD_BITS     = 10;
    localparam int SRC_CFG_BITS   = 8;
    localparam int DST_CFG_BITS   = 11;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int FRAC_BITS      = 16;

    localparam logic [SRC_CFG_BITS-1:0] SRC_SIZE_RESET = 8'd128;
    localparam logic [DST_CFG_BITS-1:0] DST_SIZE_RESET = 11'd1024;

    localparam logic FUNC_STORE   = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_WIDTH    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_HEIGHT   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ADDR,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_MX3,
        ST_MY0,
        ST_MY1,
        ST_SUM,
        ST_FIN
    } bpr_state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        RD_00,
        RD_10,
        RD_01,
        RD_11
    } rd_sel_t;

    typedef enum logic [1:0] {
        MUL_RD_WX0,
        MUL_RD_WX1,
        MUL_TOP_WY0,
        MUL_BOT_WY1
    } mul_sel_t;

    typedef struct packed {
        logic     accept;
        logic     check;
        logic     div_start;
        logic     addr_load;
        rd_sel_t  rd_sel;
        mul_sel_t mul_sel;
        acc_op_t  top_op;
        acc_op_t  bot_op;
        acc_op_t  sum_op;
        logic     out_load;
    } bpr_cmd_t;

    typedef struct packed {
        logic req_ok;
        logic div_busy;
    } bpr_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/bpr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire             clk,
    input  wire             we,
    input  wire [AW-1:0]    waddr,
    input  wire [WIDTH-1:0] wdata,
    input  wire [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/bpr_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpr_div
    import bpr_pkg::*;
#(
    parameter int PW  = 17,
    parameter int LW  = 7,
    parameter int DVW = 11,
    localparam int QW = LW + FRAC_BITS
)
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    input  wire [PW-1:0]   dividend,
    input  wire [DVW-1:0]  divisor,
    output logic           busy,
    output logic [QW-1:0]  quotient
);

    localparam int CW = $clog2(QW + 1);

    logic [DVW-1:0] rem_reg, rem_next;
    logic [QW-1:0]  sh_reg, sh_next;
    logic [DVW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           fits;

    assign trial = {rem_reg, sh_reg[QW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_next = rem_reg;
        sh_next  = sh_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = DVW'(dividend[PW-1:LW]);
            sh_next  = {dividend[LW-1:0], {FRAC_BITS{1'b0}}};
            dvs_next = divisor;
            cnt_next = CW'(QW);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? diff[DVW-1:0] : trial[DVW-1:0];
            sh_next  = {sh_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = sh_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bpr_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpr_datapath
    import bpr_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 128,
    parameter int MAX_SRC_HEIGHT = 128,
    parameter int MAX_DST_SIZE   = 1024,
    parameter int SAMPLE_BITS    = 16
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire bpr_cmd_t                cmd,
    output bpr_status_t                  status,
    input  wire                          func,
    input  wire [COORD_BITS-1:0]         column,
    input  wire [COORD_BITS-1:0]         row,
    input  wire [SAMPLE_BITS-1:0]        sample_in,
    input  wire                          cfg_we,
    input  wire [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire [CFG_DATA_BITS-1:0]      cfg_data,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic                         range_error
);

    localparam int XW    = $clog2(MAX_SRC_WIDTH);
    localparam int YW    = $clog2(MAX_SRC_HEIGHT);
    localparam int SW    = (XW > YW) ? XW : YW;
    localparam int EW    = SW + 1;
    localparam int DW    = $clog2(MAX_DST_SIZE + 1);
    localparam int PW    = COORD_BITS + SW;
    localparam int QW    = SW + FRAC_BITS;
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int B     = SAMPLE_BITS;
    localparam int TW    = B + FRAC_BITS;
    localparam int WW    = FRAC_BITS + 1;
    localparam int MW    = B + 2 * FRAC_BITS;
    localparam int FW    = TW + WW;

    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_SRC_WIDTH);
    localparam logic [WW-1:0] W_ONE      = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [B-1:0]  SIGN_BIT   = {1'b1, {(B-1){1'b0}}};
    localparam logic [MW-1:0] HALF       = {{(B+1){1'b0}}, {(2*FRAC_BITS-1){1'b0}}} |
                                           (MW'(1) << (2 * FRAC_BITS - 1));

    function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] maxv);
        logic [31:0] r;
        if (v == 32'd0)
        begin
            r = 32'd1;
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic [SRC_CFG_BITS-1:0] src_w_cfg_reg, src_h_cfg_reg;
    logic [DST_CFG_BITS-1:0] dst_w_cfg_reg, dst_h_cfg_reg;

    logic [EW-1:0] sw_eff, sh_eff, sw_m1_full, sh_m1_full;
    logic [SW-1:0] sw_m1, sh_m1;
    logic [DW-1:0] dw_eff, dh_eff, dw_m1, dh_m1;

    logic [COORD_BITS-1:0] col_reg, row_reg;
    logic                  err_reg;
    logic                  dx_one_reg, dy_one_reg;
    logic [PW-1:0]         prod_x_reg, prod_y_reg;

    logic            busy_x, busy_y;
    logic [QW-1:0]   quo_x, quo_y;
    logic [QW-1:0]   pos_x, pos_y;
    logic [SW-1:0]   x0_raw, y0_raw, x0_c, y0_c, x1_c, y1_c;
    logic [EW-1:0]   x0_p1, y0_p1;
    logic [SW-1:0]   x0_reg, x1_reg, y0_reg, y1_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;

    logic [SW-1:0] rx, ry;
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [B-1:0]  rdata, rd_biased;

    logic [WW-1:0] wx0, wx1, wy0, wy1;
    logic [TW-1:0] mul_a;
    logic [WW-1:0] mul_b;
    logic [FW-1:0] product;
    logic [MW-1:0] mul_reg;
    logic [TW-1:0] top_reg, bot_reg;
    logic [MW-1:0] sum_reg;
    logic [MW-1:0] rounded;
    logic [B-1:0]  result;
    logic [B-1:0]  value_reg;
    logic          range_error_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_cfg_reg <= SRC_SIZE_RESET;
            src_h_cfg_reg <= SRC_SIZE_RESET;
            dst_w_cfg_reg <= DST_SIZE_RESET;
            dst_h_cfg_reg <= DST_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  src_w_cfg_reg <= cfg_data[SRC_CFG_BITS-1:0];
                CFG_SOURCE_HEIGHT: src_h_cfg_reg <= cfg_data[SRC_CFG_BITS-1:0];
                CFG_DEST_WIDTH:    dst_w_cfg_reg <= cfg_data[DST_CFG_BITS-1:0];
                CFG_DEST_HEIGHT:   dst_h_cfg_reg <= cfg_data[DST_CFG_BITS-1:0];
                default:           ;
            endcase
        end
    end

    assign sw_eff     = EW'(clamp_size(32'(src_w_cfg_reg), 32'(MAX_SRC_WIDTH)));
    assign sh_eff     = EW'(clamp_size(32'(src_h_cfg_reg), 32'(MAX_SRC_HEIGHT)));
    assign dw_eff     = DW'(clamp_size(32'(dst_w_cfg_reg), 32'(MAX_DST_SIZE)));
    assign dh_eff     = DW'(clamp_size(32'(dst_h_cfg_reg), 32'(MAX_DST_SIZE)));
    assign sw_m1_full = sw_eff - EW'(1);
    assign sh_m1_full = sh_eff - EW'(1);
    assign sw_m1      = sw_m1_full[SW-1:0];
    assign sh_m1      = sh_m1_full[SW-1:0];
    assign dw_m1      = dw_eff - DW'(1);
    assign dh_m1      = dh_eff - DW'(1);

    // request capture and range check
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            col_reg <= column;
            row_reg <= row;
        end
        if (cmd.check)
        begin
            err_reg    <= !status.req_ok;
            dx_one_reg <= dw_eff == DW'(1);
            dy_one_reg <= dh_eff == DW'(1);
            prod_x_reg <= PW'(col_reg) * PW'(sw_m1);
            prod_y_reg <= PW'(row_reg) * PW'(sh_m1);
        end
    end

    assign status.req_ok   = (32'(col_reg) < 32'(dw_eff)) && (32'(row_reg) < 32'(dh_eff));
    assign status.div_busy = busy_x | busy_y;

    bpr_div #(
        .PW  (PW),
        .LW  (SW),
        .DVW (DW)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_x_reg),
        .divisor  (dw_m1),
        .busy     (busy_x),
        .quotient (quo_x)
    );

    bpr_div #(
        .PW  (PW),
        .LW  (SW),
        .DVW (DW)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_y_reg),
        .divisor  (dh_m1),
        .busy     (busy_y),
        .quotient (quo_y)
    );

    // neighbor coordinates, clamped to the last column and row
    assign pos_x  = dx_one_reg ? '0 : quo_x;
    assign pos_y  = dy_one_reg ? '0 : quo_y;
    assign x0_raw = pos_x[QW-1:FRAC_BITS];
    assign y0_raw = pos_y[QW-1:FRAC_BITS];
    assign x0_c   = (x0_raw > sw_m1) ? sw_m1 : x0_raw;
    assign y0_c   = (y0_raw > sh_m1) ? sh_m1 : y0_raw;
    assign x0_p1  = {1'b0, x0_c} + EW'(1);
    assign y0_p1  = {1'b0, y0_c} + EW'(1);
    assign x1_c   = (x0_p1 < sw_eff) ? x0_p1[SW-1:0] : sw_m1;
    assign y1_c   = (y0_p1 < sh_eff) ? y0_p1[SW-1:0] : sh_m1;

    always_ff @(posedge clk)
    begin
        if (cmd.addr_load)
        begin
            x0_reg <= x0_c;
            x1_reg <= x1_c;
            y0_reg <= y0_c;
            y1_reg <= y1_c;
            fx_reg <= pos_x[FRAC_BITS-1:0];
            fy_reg <= pos_y[FRAC_BITS-1:0];
        end
    end

    // source plane
    always_comb
    begin
        case (cmd.rd_sel)
            RD_00:
            begin
                rx = x0_reg;
                ry = y0_reg;
            end
            RD_10:
            begin
                rx = x1_reg;
                ry = y0_reg;
            end
            RD_01:
            begin
                rx = x0_reg;
                ry = y1_reg;
            end
            RD_11:
            begin
                rx = x1_reg;
                ry = y1_reg;
            end
            default:
            begin
                rx = x0_reg;
                ry = y0_reg;
            end
        endcase
    end

    assign raddr = AW'(ry) * ROW_STRIDE + AW'(rx);
    assign waddr = AW'(row) * ROW_STRIDE + AW'(column);
    assign we    = cmd.accept && (func == FUNC_STORE) &&
                   (32'(column) < 32'(MAX_SRC_WIDTH)) && (32'(row) < 32'(MAX_SRC_HEIGHT));

    bpr_ram #(
        .WIDTH (B),
        .DEPTH (DEPTH)
    ) u_plane (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (sample_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    // weighting, on a biased (offset binary) sample
    assign rd_biased = rdata ^ SIGN_BIT;
    assign wx1       = {1'b0, fx_reg};
    assign wy1       = {1'b0, fy_reg};
    assign wx0       = W_ONE - wx1;
    assign wy0       = W_ONE - wy1;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_RD_WX0:
            begin
                mul_a = TW'(rd_biased);
                mul_b = wx0;
            end
            MUL_RD_WX1:
            begin
                mul_a = TW'(rd_biased);
                mul_b = wx1;
            end
            MUL_TOP_WY0:
            begin
                mul_a = top_reg;
                mul_b = wy0;
            end
            MUL_BOT_WY1:
            begin
                mul_a = bot_reg;
                mul_b = wy1;
            end
            default:
            begin
                mul_a = top_reg;
                mul_b = wy0;
            end
        endcase
    end

    assign product = FW'(mul_a) * FW'(mul_b);

    always_ff @(posedge clk)
    begin
        mul_reg <= product[MW-1:0];

        case (cmd.top_op)
            ACC_LOAD: top_reg <= mul_reg[TW-1:0];
            ACC_ADD:  top_reg <= top_reg + mul_reg[TW-1:0];
            default:  ;
        endcase

        case (cmd.bot_op)
            ACC_LOAD: bot_reg <= mul_reg[TW-1:0];
            ACC_ADD:  bot_reg <= bot_reg + mul_reg[TW-1:0];
            default:  ;
        endcase

        case (cmd.sum_op)
            ACC_LOAD: sum_reg <= mul_reg;
            ACC_ADD:  sum_reg <= sum_reg + mul_reg;
            default:  ;
        endcase
    end

    // round half up, then undo the bias
    assign rounded = sum_reg + HALF;
    assign result  = rounded[MW-1:2*FRAC_BITS] ^ SIGN_BIT;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            value_reg       <= err_reg ? '0 : result;
            range_error_reg <= err_reg;
        end
    end

    assign value       = $signed(value_reg);
    assign range_error = range_error_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bpr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpr_ctrl
    import bpr_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              req_valid,
    input  wire              func,
    output logic             req_stall,
    output logic             rsp_valid,
    input  wire              rsp_stall,
    input  wire bpr_status_t status,
    output bpr_cmd_t         cmd
);

    bpr_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && (func == FUNC_REQUEST))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:    state_next = status.req_ok ? ST_DIV_GO : ST_FIN;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: state_next = status.div_busy ? ST_DIV_WAIT : ST_ADDR;
            ST_ADDR:     state_next = ST_RD0;
            ST_RD0:      state_next = ST_RD1;
            ST_RD1:      state_next = ST_RD2;
            ST_RD2:      state_next = ST_RD3;
            ST_RD3:      state_next = ST_MX3;
            ST_MX3:      state_next = ST_MY0;
            ST_MY0:      state_next = ST_MY1;
            ST_MY1:      state_next = ST_SUM;
            ST_SUM:      state_next = ST_FIN;
            ST_FIN:      state_next = out_free ? ST_IDLE : ST_FIN;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.rd_sel  = RD_00;
        cmd.mul_sel = MUL_RD_WX0;
        cmd.top_op  = ACC_HOLD;
        cmd.bot_op  = ACC_HOLD;
        cmd.sum_op  = ACC_HOLD;
        case (state_reg)
            ST_IDLE:     cmd.accept    = req_valid;
            ST_CHECK:    cmd.check     = 1'b1;
            ST_DIV_GO:   cmd.div_start = 1'b1;
            ST_DIV_WAIT: ;
            ST_ADDR:     cmd.addr_load = 1'b1;
            ST_RD0:      cmd.rd_sel    = RD_00;
            ST_RD1:
            begin
                cmd.rd_sel  = RD_10;
                cmd.mul_sel = MUL_RD_WX0;
            end
            ST_RD2:
            begin
                cmd.rd_sel  = RD_01;
                cmd.mul_sel = MUL_RD_WX1;
                cmd.top_op  = ACC_LOAD;
            end
            ST_RD3:
            begin
                cmd.rd_sel  = RD_11;
                cmd.mul_sel = MUL_RD_WX0;
                cmd.top_op  = ACC_ADD;
            end
            ST_MX3:
            begin
                cmd.mul_sel = MUL_RD_WX1;
                cmd.bot_op  = ACC_LOAD;
            end
            ST_MY0:
            begin
                cmd.mul_sel = MUL_TOP_WY0;
                cmd.bot_op  = ACC_ADD;
            end
            ST_MY1:
            begin
                cmd.mul_sel = MUL_BOT_WY1;
                cmd.sum_op  = ACC_LOAD;
            end
            ST_SUM:      cmd.sum_op   = ACC_ADD;
            ST_FIN:      cmd.out_load = out_free;
            default:     ;
        endcase
    end

    always_comb
    begin
        out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = state_reg != ST_IDLE;
    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bilinear_plane_resize.sv @@
// stores: written while idle, a store may follow a store in the next cycle
// requests: range check, position divide, four neighbor reads, weighting and sum, then the result
// is registered; Q = 16 + clog2(larger max source side) quotient bits; a new request is taken once idle
// out-of-range requests: go from the check straight to the result, with value zero
// the position dividers are bit-serial, one quotient bit per cycle
// reset clears control, sets sizes to 128x128 -> 1024x1024; plane contents undefined
`timescale 1ns / 1ps
`default_nettype none

module bilinear_plane_resize
    import bpr_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 128,
    parameter int MAX_SRC_HEIGHT = 128,
    parameter int MAX_DST_SIZE   = 1024,
    parameter int SAMPLE_BITS    = 16
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           req_valid,
    output logic                          req_stall,
    input  wire                           func,
    input  wire [COORD_BITS-1:0]          column,
    input  wire [COORD_BITS-1:0]          row,
    input  wire signed [SAMPLE_BITS-1:0]  sample_in,
    output logic                          rsp_valid,
    input  wire                           rsp_stall,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic                          range_error,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [CFG_INDEX_BITS-1:0]      cfg_index,
    input  wire [CFG_DATA_BITS-1:0]       cfg_data
);

    bpr_cmd_t    cmd;
    bpr_status_t status;

    assign cfg_ready = 1'b1;

    bpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .func      (func),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bpr_datapath #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_SIZE   (MAX_DST_SIZE),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .func        (func),
        .column      (column),
        .row         (row),
        .sample_in   (sample_in),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .value       (value),
        .range_error (range_error)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_stall |-> !status.div_busy)
        else $error("divider busy while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid || !rsp_stall))
        else $error("result overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && range_error) |-> (value == '0))
        else $error("range error with nonzero value");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (func == FUNC_REQUEST)) |=> req_stall)
        else $error("request accepted without starting work");
`endif

endmodule

`default_nettype wire
